/* rtl/gpc_pkg.sv */
// ----------------------------------------------------------------------------
// gpc_pkg: shared types, constants and functions of the grid path counter
// Field widths, register indexes, per-cell control word and the modular add.
// ----------------------------------------------------------------------------
package gpc_pkg;

   // fixed field widths
   localparam int VAL_W  = 30;
   localparam int ROW_W  = 20;
   localparam int COLS_W = 11;
   localparam int ROWS_W = 21;
   localparam int IDX_W  = 2;
   localparam int CSR_W  = 30;

   // defaults
   localparam int MAX_COLS_DEFAULT = 1024;
   localparam logic [VAL_W-1:0]  MODULUS_RESET   = 30'd1000000007;
   localparam logic [COLS_W-1:0] GRID_COLS_RESET = 11'd1;
   localparam logic [ROWS_W-1:0] GRID_ROWS_RESET = 21'd1;

   // configuration register indexes
   typedef enum logic [IDX_W-1:0] {
      CSR_GRID_COLS = 2'd0,
      CSR_GRID_ROWS = 2'd1,
      CSR_MODULUS   = 2'd2
   } csr_index_type;

   // position flags of one cell, passed from the cursor to the cell stage
   typedef struct packed {
      logic row_zero;
      logic col_zero;
      logic final_cell;
   } cell_ctl_type;

   // one add, then subtract the modulus once if the sum reaches it
   function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b,
                                                 input logic [VAL_W-1:0] m);
      logic [VAL_W:0] s;
      logic [VAL_W:0] t;
      s = {1'b0, a} + {1'b0, b};
      t = s - {1'b0, m};
      if (s >= {1'b0, m}) begin
         mod_add = t[VAL_W-1:0];
      end else begin
         mod_add = s[VAL_W-1:0];
      end
   endfunction

endpackage

/* rtl/gpc_if.sv */
// ----------------------------------------------------------------------------
// gpc_req_if / gpc_rsp_if: valid/ready channels of the grid path counter
// One word is moved at a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface gpc_req_if;
   logic valid;
   logic ready;
   logic is_wall;
   logic first_cell;

   modport source (output valid, output is_wall, output first_cell, input ready);
   modport sink   (input valid, input is_wall, input first_cell, output ready);
endinterface

interface gpc_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [gpc_pkg::VAL_W-1:0]  path_count;
   logic                       final_cell;

   modport source (output valid, output path_count, output final_cell, input ready);
   modport sink   (input valid, input path_count, input final_cell, output ready);
endinterface

/* rtl/gpc_line_ram.sv */
// ----------------------------------------------------------------------------
// gpc_line_ram: line buffer holding the vertical and diagonal sums per column
// One write and one registered read per cycle; a read of the address being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module gpc_line_ram #(
   parameter int MAX_COLS = gpc_pkg::MAX_COLS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_COLS)-1:0]   wr_addr,
   input  logic [2*gpc_pkg::VAL_W-1:0]   wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_COLS)-1:0]   rd_addr,
   output logic [2*gpc_pkg::VAL_W-1:0]   rd_data
);

   localparam int WORD_W = 2 * gpc_pkg::VAL_W;

   logic [WORD_W-1:0] mem [MAX_COLS];
   logic [WORD_W-1:0] rd_data_ff;
   logic [WORD_W-1:0] fwd_data_ff;
   logic              fwd_sel_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, with bypass of a same-cycle write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_sel_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_sel_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign rd_data = fwd_sel_ff ? fwd_data_ff : rd_data_ff;

endmodule

/* rtl/gpc_cursor.sv */
// ----------------------------------------------------------------------------
// gpc_cursor: raster position of the incoming cell
// Tracks row and column, wraps at the column count and flags the final cell.
// ----------------------------------------------------------------------------
module gpc_cursor #(
   parameter int MAX_COLS = gpc_pkg::MAX_COLS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          first_cell,
   input  logic [gpc_pkg::COLS_W-1:0]    grid_cols,
   input  logic [gpc_pkg::ROWS_W-1:0]    grid_rows,
   output logic [$clog2(MAX_COLS)-1:0]   col,
   output gpc_pkg::cell_ctl_type         ctl
);

   localparam int COL_W = $clog2(MAX_COLS);
   localparam int CNT_W = COL_W + 1;

   logic [gpc_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]           col_ff, col_in;
   logic [CNT_W-1:0]           eff_cols;
   logic [gpc_pkg::ROWS_W-1:0] eff_rows;
   logic [gpc_pkg::ROW_W-1:0]  cur_row;
   logic [COL_W-1:0]           cur_col;
   logic [CNT_W-1:0]           col_plus;
   logic [gpc_pkg::ROWS_W-1:0] row_plus;
   logic                       last_col;

   // effective column and row counts
   always_comb begin
      if (grid_cols == '0) begin
         eff_cols = CNT_W'(1);
      end else if (32'(grid_cols) > 32'(MAX_COLS)) begin
         eff_cols = CNT_W'(MAX_COLS);
      end else begin
         eff_cols = CNT_W'(grid_cols);
      end
      eff_rows = (grid_rows == '0) ? gpc_pkg::ROWS_W'(1) : grid_rows;
   end

   // position of this cell, then of the next one
   always_comb begin
      if (first_cell) begin
         cur_row = '0;
         cur_col = '0;
      end else if ({1'b0, col_ff} >= eff_cols) begin
         cur_row = row_ff + gpc_pkg::ROW_W'(1);
         cur_col = '0;
      end else begin
         cur_row = row_ff;
         cur_col = col_ff;
      end
      col_plus = {1'b0, cur_col} + CNT_W'(1);
      row_plus = {1'b0, cur_row} + gpc_pkg::ROWS_W'(1);
      last_col = (col_plus == eff_cols);
      if (last_col) begin
         col_in = '0;
         row_in = cur_row + gpc_pkg::ROW_W'(1);
      end else begin
         col_in = col_plus[COL_W-1:0];
         row_in = cur_row;
      end
      col            = cur_col;
      ctl.row_zero   = (cur_row == '0);
      ctl.col_zero   = (cur_col == '0);
      ctl.final_cell = last_col && (row_plus == eff_rows);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (advance) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

endmodule

/* rtl/gpc_cell.sv */
// ----------------------------------------------------------------------------
// gpc_cell: per-cell path count stage and output register
// Combines the line buffer sums with the horizontal sum, writes the new sums
// back and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module gpc_cell #(
   parameter int MAX_COLS = gpc_pkg::MAX_COLS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [$clog2(MAX_COLS)-1:0]   col,
   input  gpc_pkg::cell_ctl_type         ctl,
   input  logic                          is_wall,
   input  logic [gpc_pkg::VAL_W-1:0]     modulus,
   input  logic [2*gpc_pkg::VAL_W-1:0]   rd_data,
   output logic                          in_ready,
   output logic                          wr_en,
   output logic [$clog2(MAX_COLS)-1:0]   wr_addr,
   output logic [2*gpc_pkg::VAL_W-1:0]   wr_data,
   gpc_rsp_if.source                     rsp_port
);

   localparam int VW    = gpc_pkg::VAL_W;
   localparam int COL_W = $clog2(MAX_COLS);

   logic                  s1_valid_ff;
   logic [COL_W-1:0]      s1_col_ff;
   gpc_pkg::cell_ctl_type s1_ctl_ff;
   logic                  s1_wall_ff;
   logic [VW-1:0]         horiz_ff;
   logic [VW-1:0]         diag_left_ff;
   logic                  out_valid_ff;
   logic [VW-1:0]         out_count_ff;
   logic                  out_final_ff;

   logic                  fire;
   logic [VW-1:0]         up, old_diag, left, diag;
   logic [VW-1:0]         sum_ul, count_open, count;
   logic [VW-1:0]         vert_new, diag_new, horiz_new;

   assign fire     = s1_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign in_ready = !s1_valid_ff || fire;

   // path count and updated running sums
   always_comb begin
      up       = s1_ctl_ff.row_zero ? '0 : rd_data[2*VW-1:VW];
      old_diag = s1_ctl_ff.row_zero ? '0 : rd_data[VW-1:0];
      left     = s1_ctl_ff.col_zero ? '0 : horiz_ff;
      diag     = (s1_ctl_ff.row_zero || s1_ctl_ff.col_zero) ? '0 : diag_left_ff;
      sum_ul   = gpc_pkg::mod_add(up, left, modulus);
      if (s1_ctl_ff.row_zero && s1_ctl_ff.col_zero) begin
         count_open = gpc_pkg::mod_add('0, VW'(1), modulus);
      end else begin
         count_open = gpc_pkg::mod_add(sum_ul, diag, modulus);
      end
      if (s1_wall_ff) begin
         count     = '0;
         vert_new  = '0;
         diag_new  = '0;
         horiz_new = '0;
      end else begin
         count     = count_open;
         vert_new  = gpc_pkg::mod_add(up, count_open, modulus);
         diag_new  = gpc_pkg::mod_add(diag, count_open, modulus);
         horiz_new = gpc_pkg::mod_add(left, count_open, modulus);
      end
   end

   // write-back to the line buffer
   assign wr_en   = fire;
   assign wr_addr = s1_col_ff;
   assign wr_data = {vert_new, diag_new};

   // cell stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (load) begin
         s1_valid_ff <= 1'b1;
      end else if (fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_col_ff  <= col;
         s1_ctl_ff  <= ctl;
         s1_wall_ff <= is_wall;
      end
   end

   // horizontal sum and diagonal of the cell above-left
   always_ff @(posedge clock) begin
      if (reset) begin
         horiz_ff     <= '0;
         diag_left_ff <= '0;
      end else if (fire) begin
         horiz_ff     <= horiz_new;
         diag_left_ff <= old_diag;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_port.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_count_ff <= count;
         out_final_ff <= s1_ctl_ff.final_cell;
      end
   end

   assign rsp_port.valid      = out_valid_ff;
   assign rsp_port.path_count = out_count_ff;
   assign rsp_port.final_cell = out_final_ff;

endmodule

/* rtl/grid_line_move_path_count.sv */
// ----------------------------------------------------------------------------
// grid_line_move_path_count: streaming grid path counter
// Cells in raster order in, one path count word out per cell.
// ----------------------------------------------------------------------------
// One cell is accepted every clock cycle unless rsp_port stalls; each gives
// one result word via the cell stage register and then the output register.
// The rate is set by the horizontal-sum loop in the cell stage, which does
// three dependent modular adds per cycle, and by the line buffer, which is
// read as a cell enters the cell stage and written back when it completes;
// a read of the column being written is bypassed. The line buffer needs no
// clearing after reset. Write configuration only while no cell is in flight.
// ----------------------------------------------------------------------------
module grid_line_move_path_count #(
   parameter int MAX_COLS = gpc_pkg::MAX_COLS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   gpc_req_if.sink                    req_port,
   gpc_rsp_if.source                  rsp_port,
   input  logic                       csr_we,
   input  logic [gpc_pkg::IDX_W-1:0]  csr_index,
   input  logic [gpc_pkg::CSR_W-1:0]  csr_data
);

   localparam int COL_W = $clog2(MAX_COLS);

   logic [gpc_pkg::COLS_W-1:0] grid_cols_ff;
   logic [gpc_pkg::ROWS_W-1:0] grid_rows_ff;
   logic [gpc_pkg::VAL_W-1:0]  modulus_ff;

   logic                          accept;
   logic                          in_ready;
   logic [COL_W-1:0]              cur_col;
   gpc_pkg::cell_ctl_type         cur_ctl;
   logic                          wr_en;
   logic [COL_W-1:0]              wr_addr;
   logic [2*gpc_pkg::VAL_W-1:0]   wr_data;
   logic [2*gpc_pkg::VAL_W-1:0]   rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= gpc_pkg::GRID_COLS_RESET;
         grid_rows_ff <= gpc_pkg::GRID_ROWS_RESET;
         modulus_ff   <= gpc_pkg::MODULUS_RESET;
      end else if (csr_we) begin
         case (gpc_pkg::csr_index_type'(csr_index))
            gpc_pkg::CSR_GRID_COLS: grid_cols_ff <= csr_data[gpc_pkg::COLS_W-1:0];
            gpc_pkg::CSR_GRID_ROWS: grid_rows_ff <= csr_data[gpc_pkg::ROWS_W-1:0];
            gpc_pkg::CSR_MODULUS:   modulus_ff   <= csr_data[gpc_pkg::VAL_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_port.ready = in_ready;
   assign accept         = req_port.valid && in_ready;

   // raster position
   gpc_cursor #(.MAX_COLS(MAX_COLS)) u_cursor (
      .clock      (clock),
      .reset      (reset),
      .advance    (accept),
      .first_cell (req_port.first_cell),
      .grid_cols  (grid_cols_ff),
      .grid_rows  (grid_rows_ff),
      .col        (cur_col),
      .ctl        (cur_ctl)
   );

   // column sums of the row above
   gpc_line_ram #(.MAX_COLS(MAX_COLS)) u_line_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (rd_data)
   );

   // count, write-back and result word
   gpc_cell #(.MAX_COLS(MAX_COLS)) u_cell (
      .clock    (clock),
      .reset    (reset),
      .load     (accept),
      .col      (cur_col),
      .ctl      (cur_ctl),
      .is_wall  (req_port.is_wall),
      .modulus  (modulus_ff),
      .rd_data  (rd_data),
      .in_ready (in_ready),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rsp_port (rsp_port)
   );

endmodule

/* rtl/gpc_checker.sv */
// ----------------------------------------------------------------------------
// gpc_checker: port-level checks of the grid path counter
// Tracks words in flight and checks result hold, depth and the empty state
// after reset.
// ----------------------------------------------------------------------------
module gpc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [gpc_pkg::VAL_W-1:0] rsp_path_count,
   input logic                      rsp_final_cell
);

   logic [2:0] in_flight_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // words accepted and not yet delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_ff + 3'(req_take) - 3'(rsp_take);
      end
   end

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_path_count)
                                && $stable(rsp_final_cell))
      else $error("result word changed while stalled");

   // no result without a cell in flight
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff == 3'd0 |-> !rsp_valid)
      else $error("result word without an accepted cell");

   // pipeline holds at most two cells
   a_depth: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff <= 3'd2)
      else $error("more than two cells in flight");

   // output is empty at the first edge out of reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind grid_line_move_path_count gpc_checker u_gpc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_port.valid),
   .req_ready      (req_port.ready),
   .rsp_valid      (rsp_port.valid),
   .rsp_ready      (rsp_port.ready),
   .rsp_path_count (rsp_port.path_count),
   .rsp_final_cell (rsp_port.final_cell)
);
